/* src/vnorm_pkg.sv */
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared widths and types for the 3D vector normalise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vnorm_pkg;

  localparam int unsigned CompW  = 32;         // component width, Q16.16 in, Q1.30 out
  localparam int unsigned SumW   = 2 * CompW;  // sum of squares
  localparam int unsigned RootW  = 32;         // integer square root of SumW bits
  localparam int unsigned RemW   = RootW + 3;  // square root partial remainder
  localparam int unsigned QuoW   = 31;         // quotient bits, at most 2^30
  localparam int unsigned NumLanes = 3;

  typedef logic [CompW-1:0] comp_t;
  typedef logic [NumLanes-1:0][CompW-1:0] vec_t;

  typedef struct packed {
    logic [NumLanes-1:0] neg;   // sign of each input component
    logic                zero;  // sum of squares was zero
  } vnorm_side_t;

endpackage

`default_nettype wire

/* src/vector3_normalize_unit.sv */
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// Scales a Q16.16 vector to unit length, Q1.30 out, truncated toward zero.
// ----------------------------------------------------------------------------
//  channel | ports                                  | beat
//  --------+----------------------------------------+---------------------------
//  in      | in_valid/in_ready, in_x_in..in_z_in    | one vector, Q16.16
//  out     | out_valid/out_ready, out_x_unit..z,    | unit vector, Q1.30,
//          | out_was_zero                           | zero flag
//
//  One beat a cycle enters and leaves while the output is not stalled; stages:
//  three for squares and sum, 32 for the bit-per-stage square root, 31 for the
//  bit-per-stage dividers, one for sign and zero handling at the output register.
//  Synchronous active-low reset clears the valid bits only.
//  A stalled output holds the whole pipeline in place; in_ready follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize_unit import vnorm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire comp_t in_x_in,
  input  wire comp_t in_y_in,
  input  wire comp_t in_z_in,
  output logic       out_valid,
  input  wire logic  out_ready,
  output comp_t      out_x_unit,
  output comp_t      out_y_unit,
  output comp_t      out_z_unit,
  output logic       out_was_zero
);

  logic                          adv;
  logic                          sq_valid;
  logic [SumW-1:0]               sq_sum;
  vec_t                          sq_abs;
  vnorm_side_t                   sq_side;
  logic                          rt_valid;
  logic [RootW-1:0]              rt_root;
  vec_t                          rt_abs;
  vnorm_side_t                   rt_side;
  logic                          dv_valid;
  logic [NumLanes-1:0][QuoW-1:0] dv_quo;
  vnorm_side_t                   dv_side;

  logic                          out_valid_r;
  vec_t                          unit_r;
  logic                          zero_r;
  vec_t                          unit_nxt;

  // advance whenever the output slot is free or being taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  vnorm_sq u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_x     (in_x_in),
    .in_y     (in_y_in),
    .in_z     (in_z_in),
    .sq_valid (sq_valid),
    .sq_sum   (sq_sum),
    .sq_abs   (sq_abs),
    .sq_side  (sq_side)
  );

  vnorm_sqrt u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .rt_valid_in (sq_valid),
    .rt_sum      (sq_sum),
    .rt_abs_in   (sq_abs),
    .rt_side_in  (sq_side),
    .rt_valid    (rt_valid),
    .rt_root     (rt_root),
    .rt_abs      (rt_abs),
    .rt_side     (rt_side)
  );

  vnorm_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .dv_valid_in (rt_valid),
    .dv_mag      (rt_root),
    .dv_abs      (rt_abs),
    .dv_side_in  (rt_side),
    .dv_valid    (dv_valid),
    .dv_quo      (dv_quo),
    .dv_side     (dv_side)
  );

  // apply sign; drop the meaningless quotient of a zero vector
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (dv_side.zero) begin
        unit_nxt[l] = '0;
      end else if (dv_side.neg[l]) begin
        unit_nxt[l] = comp_t'(0) - CompW'(dv_quo[l]);
      end else begin
        unit_nxt[l] = CompW'(dv_quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r <= unit_nxt;
      zero_r <= dv_side.zero;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x_unit   = unit_r[0];
  assign out_y_unit   = unit_r[1];
  assign out_z_unit   = unit_r[2];
  assign out_was_zero = zero_r;

endmodule

`default_nettype wire

/* src/vnorm_sq.sv */
// ----------------------------------------------------------------------------
// vnorm_sq
// Front end: absolute values, squares and sum of squares over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_sq import vnorm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire comp_t           in_x,
  input  wire comp_t           in_y,
  input  wire comp_t           in_z,
  output logic                 sq_valid,
  output logic [SumW-1:0]      sq_sum,
  output vec_t                 sq_abs,
  output vnorm_side_t          sq_side
);

  logic                         va_r, vb_r, vc_r;
  vec_t                         abs_a_r, abs_b_r, abs_c_r;
  logic [NumLanes-1:0]          neg_a_r, neg_b_r, neg_c_r;
  logic [NumLanes-1:0][SumW-1:0] prod_r;
  logic [SumW-1:0]              sum_r;
  logic                         zero_r;

  vec_t                         comp_in;
  vec_t                         abs_nxt;
  logic [NumLanes-1:0]          neg_nxt;
  logic [NumLanes-1:0][SumW-1:0] prod_nxt;
  logic [SumW-1:0]              sum_nxt;

  assign comp_in = {in_z, in_y, in_x};

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      neg_nxt[i]  = comp_in[i][CompW-1];
      // the most negative value maps to 2^31, which still fits unsigned
      abs_nxt[i]  = neg_nxt[i] ? (~comp_in[i] + comp_t'(1)) : comp_in[i];
      prod_nxt[i] = SumW'(abs_a_r[i]) * SumW'(abs_a_r[i]);
    end
    sum_nxt = prod_r[0] + prod_r[1] + prod_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abs_a_r <= abs_nxt;
      neg_a_r <= neg_nxt;
      abs_b_r <= abs_a_r;
      neg_b_r <= neg_a_r;
      prod_r  <= prod_nxt;
      abs_c_r <= abs_b_r;
      neg_c_r <= neg_b_r;
      sum_r   <= sum_nxt;
      zero_r  <= (sum_nxt == '0);
    end
  end

  assign sq_valid     = vc_r;
  assign sq_sum       = sum_r;
  assign sq_abs       = abs_c_r;
  assign sq_side.neg  = neg_c_r;
  assign sq_side.zero = zero_r;

endmodule

`default_nettype wire

/* src/vnorm_sqrt.sv */
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_sqrt import vnorm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            rt_valid_in,
  input  wire logic [SumW-1:0] rt_sum,
  input  wire vec_t            rt_abs_in,
  input  wire vnorm_side_t     rt_side_in,
  output logic                 rt_valid,
  output logic [RootW-1:0]     rt_root,
  output vec_t                 rt_abs,
  output vnorm_side_t          rt_side
);

  logic              valid_r [RootW];
  logic [SumW-1:0]   n_r     [RootW];
  logic [RemW-1:0]   rem_r   [RootW];
  logic [RootW-1:0]  root_r  [RootW];
  vec_t              abs_r   [RootW];
  vnorm_side_t       side_r  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic              v_in;
    logic [SumW-1:0]   n_in;
    logic [RemW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    vec_t              abs_in;
    vnorm_side_t       side_in;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;
    logic              ge;
    logic [RemW-1:0]   rem_nxt;
    logic [RootW-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = rt_valid_in;
      assign n_in    = rt_sum;
      assign rem_in  = '0;
      assign root_in = '0;
      assign abs_in  = rt_abs_in;
      assign side_in = rt_side_in;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign abs_in  = abs_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down the next two bits and try root*4+1
    always_comb begin
      rem_sh   = {rem_in[RemW-3:0], n_in[SumW-1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[RootW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[k]    <= {n_in[SumW-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        abs_r[k]  <= abs_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign rt_valid = valid_r[RootW-1];
  assign rt_root  = root_r[RootW-1];
  assign rt_abs   = abs_r[RootW-1];
  assign rt_side  = side_r[RootW-1];

endmodule

`default_nettype wire

/* src/vnorm_div.sv */
// ----------------------------------------------------------------------------
// vnorm_div
// Three-lane restoring divider, |c| * 2^30 / m, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_div import vnorm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             dv_valid_in,
  input  wire logic [RootW-1:0] dv_mag,
  input  wire vec_t             dv_abs,
  input  wire vnorm_side_t      dv_side_in,
  output logic                  dv_valid,
  output logic [NumLanes-1:0][QuoW-1:0] dv_quo,
  output vnorm_side_t           dv_side
);

  logic                                  valid_r [QuoW];
  logic [RootW-1:0]                      mag_r   [QuoW];
  logic [NumLanes-1:0][RootW-1:0]        rem_r   [QuoW];
  logic [NumLanes-1:0][QuoW-1:0]         quo_r   [QuoW];
  vnorm_side_t                           side_r  [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    logic                           v_in;
    logic [RootW-1:0]               mag_in;
    logic [NumLanes-1:0][RootW-1:0] rem_in;
    logic [NumLanes-1:0][QuoW-1:0]  quo_in;
    logic [NumLanes-1:0]            bit_in;
    vnorm_side_t                    side_in;
    logic [NumLanes-1:0][RootW:0]   rem2;
    logic [NumLanes-1:0]            ge;
    logic [NumLanes-1:0][RootW-1:0] rem_nxt;
    logic [NumLanes-1:0][QuoW-1:0]  quo_nxt;

    if (j == 0) begin : g_first
      // numerator is |c| << 30: start from |c| >> 1, bring down |c|[0], then zeros
      always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
          rem_in[l] = RootW'(dv_abs[l][CompW-1:1]);
          bit_in[l] = dv_abs[l][0];
        end
      end
      assign v_in    = dv_valid_in;
      assign mag_in  = dv_mag;
      assign quo_in  = '0;
      assign side_in = dv_side_in;
    end else begin : g_next
      assign v_in    = valid_r[j-1];
      assign mag_in  = mag_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign bit_in  = '0;
      assign side_in = side_r[j-1];
    end

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        rem2[l]    = {rem_in[l], bit_in[l]};
        ge[l]      = (rem2[l] >= {1'b0, mag_in});
        rem_nxt[l] = ge[l] ? RootW'(rem2[l] - {1'b0, mag_in}) : RootW'(rem2[l]);
        quo_nxt[l] = {quo_in[l][QuoW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (adv) begin
        valid_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mag_r[j]  <= mag_in;
        rem_r[j]  <= rem_nxt;
        quo_r[j]  <= quo_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign dv_valid = valid_r[QuoW-1];
  assign dv_quo   = quo_r[QuoW-1];
  assign dv_side  = side_r[QuoW-1];

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks vector3_normalize_unit against an in-bench predictor: directed corner
// vectors, then random vectors across magnitudes, with bursty stalls both ways but a stall-free tail.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import vnorm_pkg::*;

  localparam int unsigned LatencyCycles = 67;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomVecs    = 400;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_beat_t;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  zero;
  } unit_beat_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  comp_t in_x_in = '0;
  comp_t in_y_in = '0;
  comp_t in_z_in = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  comp_t out_x_unit;
  comp_t out_y_unit;
  comp_t out_z_unit;
  logic  out_was_zero;

  vec_beat_t  pending_vecs[$];
  unit_beat_t expected_units[$];
  int unsigned mismatch_cnt = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned zero_seen = 0;
  int unsigned idle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit no_stalls = 1'b0;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  vector3_normalize_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] probe;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      probe = res | (64'd1 << b);
      if (probe * probe <= n) res = probe;
    end
    return res;
  endfunction

  function automatic unit_beat_t normalise_vec(vec_beat_t v);
    unit_beat_t r;
    logic [63:0] ax, ay, az, sq_sum, mag;
    // abs of -2^31 is 2^31, so widen before squaring
    ax = v.x[31] ? 64'(33'h1_0000_0000 - {1'b0, v.x}) : {32'd0, v.x};
    ay = v.y[31] ? 64'(33'h1_0000_0000 - {1'b0, v.y}) : {32'd0, v.y};
    az = v.z[31] ? 64'(33'h1_0000_0000 - {1'b0, v.z}) : {32'd0, v.z};
    sq_sum = ax * ax + ay * ay + az * az;
    if (sq_sum == 0) begin
      r = '{x: '0, y: '0, z: '0, zero: 1'b1};
    end else begin
      mag = root_floor(sq_sum);
      r.x = v.x[31] ? 32'(-((ax << 30) / mag)) : 32'((ax << 30) / mag);
      r.y = v.y[31] ? 32'(-((ay << 30) / mag)) : 32'((ay << 30) / mag);
      r.z = v.z[31] ? 32'(-((az << 30) / mag)) : 32'((az << 30) / mag);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  function automatic comp_t rand_comp();
    comp_t c;
    case ($urandom_range(0, 5))
      0: c = $urandom();
      1: c = $urandom_range(0, 255);
      2: c = -$urandom_range(0, 255);
      3: c = $urandom() >> $urandom_range(0, 31);
      4: c = 32'h8000_0000 | ($urandom() >> $urandom_range(1, 31));
      default: c = $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                   ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0001_0000);
    endcase
    return c;
  endfunction

  task automatic queue_vec(comp_t x, comp_t y, comp_t z);
    pending_vecs.push_back('{x: x, y: y, z: z});
  endtask

  // remember whether the last rising edge took the input beat
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // driver: advance on accept, hold payload while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0 && !no_stalls) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_vecs.size() > 0 && !hold_send) begin
          in_x_in  <= pending_vecs[0].x;
          in_y_in  <= pending_vecs[0].y;
          in_z_in  <= pending_vecs[0].z;
          in_valid <= 1'b1;
          void'(pending_vecs.pop_front());
          if ($urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0 && !no_stalls) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 11);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    unit_beat_t exp_u;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_units.push_back(normalise_vec('{x: in_x_in, y: in_y_in, z: in_z_in}));
        beats_sent++;
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (out_was_zero) zero_seen++;
        if (expected_units.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected beat: %h %h %h z=%b",
                     out_x_unit, out_y_unit, out_z_unit, out_was_zero);
        end else begin
          exp_u = expected_units.pop_front();
          if (out_x_unit !== exp_u.x || out_y_unit !== exp_u.y ||
              out_z_unit !== exp_u.z || out_was_zero !== exp_u.zero) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp %h %h %h z=%b, got %h %h %h z=%b",
                       exp_u.x, exp_u.y, exp_u.z, exp_u.zero,
                       out_x_unit, out_y_unit, out_z_unit, out_was_zero);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cnt >= WatchdogLimit) begin
      $display("watchdog: no progress, %0d results outstanding", expected_units.size());
      $display("FAIL vector3_normalize_unit");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_vec('0, '0, '0);
    queue_vec(32'h0001_0000, '0, '0);
    queue_vec('0, 32'hffff_0000, '0);
    queue_vec('0, '0, 32'h8000_0000);
    queue_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_vec(32'h7fff_ffff, 32'h8000_0000, 32'd1);
    queue_vec(32'd1, 32'd1, 32'd1);
    queue_vec(32'hffff_ffff, '0, '0);
    queue_vec(32'd3, 32'd4, '0);
    queue_vec(32'hffff_fffd, '0, 32'hffff_fffc);
    queue_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    queue_vec(32'd1, 32'h7fff_ffff, '0);

    // pause until everything in flight has drained
    wait (pending_vecs.size() == 0);
    hold_send = 1'b1;
    @(posedge clk);
    wait (expected_units.size() == 0 && !in_valid);
    hold_send = 1'b0;

    for (int i = 0; i < RandomVecs; i++) begin
      if (i == RandomVecs - 60) begin
        wait (pending_vecs.size() == 0);
        no_stalls = 1'b1;
      end
      queue_vec(rand_comp(), rand_comp(), rand_comp());
    end
    wait (pending_vecs.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_units.size() == 0);
    repeat (LatencyCycles + 10) @(posedge clk);

    $display("covered %0d vectors incl. zero, full-scale and -2^31 corners; %0d zero flags",
             beats_seen, zero_seen);
    if (mismatch_cnt == 0 && expected_units.size() == 0) begin
      $display("PASS vector3_normalize_unit");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAIL vector3_normalize_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
